@@ rtl/rspt_pkg.sv @@
`default_nettype none

package rspt_pkg;

    localparam int NUM_REELS   = 7;
    localparam int REEL_COUNT  = 7;
    localparam int PHASE_REELS = 6;
    localparam int POS_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [POS_W-1:0] STEPS_PER_TURN = 7'd96;
    localparam logic [POS_W-1:0] POS_RESET      = 7'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UNI_OPTO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 1'b1;

    // sensor window rules
    localparam logic [1:0] WIN_RULE_WIDE   = 2'd0;
    localparam logic [1:0] WIN_RULE_OFFSET = 2'd1;
    localparam logic [1:0] WIN_RULE_MID    = 2'd2;
    localparam logic [1:0] WIN_RULE_NARROW = 2'd3;

    typedef enum logic [3:0] {
        OP_BIPOLAR = 4'd0,
        OP_X       = 4'd1,
        OP_Y       = 4'd2,
        OP_Z       = 4'd3,
        OP_GATHER5 = 4'd4,
        OP_HIGH5   = 4'd5,
        OP_MID5    = 4'd6,
        OP_REEL45  = 4'd7,
        OP_GATHER7 = 4'd8
    } op_t;

    typedef logic signed [2:0] step_t;

    localparam step_t Z0 = 3'sd0;
    localparam step_t P1 = 3'sd1;
    localparam step_t P2 = 3'sd2;
    localparam step_t P3 = 3'sd3;
    localparam step_t M1 = -3'sd1;
    localparam step_t M2 = -3'sd2;
    localparam step_t M3 = -3'sd3;

    // row: position mod 8, column: unipolar drive nibble
    localparam step_t UNI_TAB [8][16] = '{
        '{Z0, P1, P3, P2, M3, Z0, Z0, Z0, M1, Z0, Z0, Z0, M2, Z0, Z0, Z0},
        '{Z0, Z0, P2, P1, Z0, Z0, P3, Z0, M2, M1, Z0, Z0, M3, Z0, Z0, Z0},
        '{Z0, M1, P1, Z0, P3, Z0, P2, Z0, M3, M2, Z0, Z0, Z0, Z0, Z0, Z0},
        '{Z0, M2, Z0, M1, P2, Z0, P1, Z0, Z0, M3, Z0, Z0, P3, Z0, Z0, Z0},
        '{Z0, M3, M1, M2, P1, Z0, Z0, Z0, P3, Z0, Z0, Z0, P2, Z0, Z0, Z0},
        '{Z0, Z0, M2, M3, Z0, Z0, M1, Z0, P2, P3, Z0, Z0, P1, Z0, Z0, Z0},
        '{Z0, P3, M3, Z0, M1, Z0, M2, Z0, P1, P2, Z0, Z0, Z0, Z0, Z0, Z0},
        '{Z0, P2, Z0, P3, M2, Z0, M3, Z0, Z0, P1, Z0, Z0, M1, Z0, Z0, Z0}
    };

    // row: position mod 8, column: bipolar 2-bit drive
    localparam step_t BI_TAB [8][4] = '{
        '{P2, Z0, Z0, M2},
        '{Z0, Z0, Z0, Z0},
        '{Z0, M2, P2, Z0},
        '{Z0, Z0, Z0, Z0},
        '{M2, Z0, Z0, P2},
        '{Z0, Z0, Z0, Z0},
        '{Z0, P2, M2, Z0},
        '{Z0, Z0, Z0, Z0}
    };

    typedef struct packed {
        logic [NUM_REELS-1:0][POS_W-1:0] motor_pos;
        logic [NUM_REELS-1:0][POS_W-1:0] shown_pos;
        logic [PHASE_REELS-1:0][3:0]     last_phase;
        logic [7:0]                      sensor;
    } reel_state_t;

    typedef struct packed {
        logic       uni_opto;
        logic [7:0] window;
    } cfg_t;

    // position plus step, wrapped into one turn
    function automatic logic [POS_W-1:0] wrap_pos(input logic [POS_W-1:0] pos,
                                                  input step_t delta);
        logic signed [8:0] sum;
        logic signed [8:0] res;
        sum = $signed({2'b00, pos}) + $signed({{6{delta[2]}}, delta});
        if (sum < 0)
            res = sum + $signed({2'b00, STEPS_PER_TURN});
        else if (sum >= $signed({2'b00, STEPS_PER_TURN}))
            res = sum - $signed({2'b00, STEPS_PER_TURN});
        else
            res = sum;
        return res[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/rspt_step.sv @@
`default_nettype none

module rspt_step (
    input  wire rspt_pkg::reel_state_t         cur,
    input  wire rspt_pkg::cfg_t                cfg,
    input  wire logic [3:0]                    op,
    input  wire logic [7:0]                    data,
    output rspt_pkg::reel_state_t              nxt,
    output logic [rspt_pkg::NUM_REELS-1:0]     moved
);

    logic [rspt_pkg::NUM_REELS-1:0]        uni_en;
    logic [rspt_pkg::NUM_REELS-1:0][3:0]   nib;
    logic [rspt_pkg::PHASE_REELS-1:0]      lp_en;
    logic                                  bi_en;
    logic [3:0]                            gathered;
    rspt_pkg::step_t                       delta;
    logic [rspt_pkg::POS_W-1:0]            new_pos;
    logic [2:0]                            row;

    function automatic logic pair_gate(input logic [3:0] n, input logic [3:0] last);
        return (n != 4'd0) && (n != last);
    endfunction

    function automatic logic window_hit(input logic [1:0] rule,
                                        input logic [rspt_pkg::POS_W-1:0] p);
        logic hit;
        unique case (rule)
            rspt_pkg::WIN_RULE_WIDE:   hit = (p < 7'd4) || (p > 7'd92);
            rspt_pkg::WIN_RULE_OFFSET: hit = (p > 7'd4) && (p < 7'd12);
            rspt_pkg::WIN_RULE_MID:    hit = (p < 7'd3) || (p > 7'd92);
            rspt_pkg::WIN_RULE_NARROW: hit = (p < 7'd2) || (p > 7'd93);
            default:                   hit = 1'b0;
        endcase
        return hit;
    endfunction

    assign gathered = {data[7], data[5], data[3], data[0]};

    // port decode: which reels get a nibble
    always_comb
    begin
        uni_en = '0;
        nib    = '0;
        lp_en  = '0;
        bi_en  = 1'b0;
        unique case (op)
            rspt_pkg::OP_BIPOLAR:
            begin
                bi_en = 1'b1;
            end
            rspt_pkg::OP_X:
            begin
                nib[2]    = data[3:0];
                nib[3]    = data[7:4];
                uni_en[2] = pair_gate(data[3:0], cur.last_phase[2]);
                uni_en[3] = pair_gate(data[7:4], cur.last_phase[3]);
                lp_en[2]  = uni_en[2];
                lp_en[3]  = uni_en[3];
            end
            rspt_pkg::OP_Y:
            begin
                nib[0]    = data[3:0];
                nib[1]    = data[7:4];
                uni_en[0] = pair_gate(data[3:0], cur.last_phase[0]);
                uni_en[1] = pair_gate(data[7:4], cur.last_phase[1]);
                lp_en[0]  = uni_en[0];
                lp_en[1]  = uni_en[1];
            end
            rspt_pkg::OP_Z:
            begin
                nib[4]    = data[3:0];
                nib[5]    = data[7:4];
                uni_en[4] = pair_gate(data[3:0], cur.last_phase[4]);
                uni_en[5] = pair_gate(data[7:4], cur.last_phase[5]);
                lp_en[4]  = uni_en[4];
                lp_en[5]  = uni_en[5];
            end
            rspt_pkg::OP_GATHER5:
            begin
                nib[4]    = gathered;
                uni_en[4] = 1'b1;
            end
            rspt_pkg::OP_HIGH5:
            begin
                nib[4]    = data[7:4];
                uni_en[4] = 1'b1;
            end
            rspt_pkg::OP_MID5:
            begin
                nib[4]    = data[5:2];
                uni_en[4] = 1'b1;
            end
            rspt_pkg::OP_REEL45:
            begin
                nib[4]    = data[3:0];
                nib[5]    = data[7:4];
                uni_en[4] = 1'b1;
                uni_en[5] = 1'b1;
            end
            rspt_pkg::OP_GATHER7:
            begin
                nib[6]    = gathered;
                uni_en[6] = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // per-reel step, position and sensor update
    always_comb
    begin
        nxt   = cur;
        moved = '0;
        delta   = rspt_pkg::Z0;
        new_pos = '0;
        row     = '0;
        for (int r = 0; r < rspt_pkg::NUM_REELS; r++)
        begin
            row = cur.motor_pos[r][2:0];
            // only reels 0..3 have a bipolar drive or a window rule
            if (bi_en && (r < 4))
                delta = rspt_pkg::BI_TAB[row][data[2*(r & 3) +: 2]];
            else if (uni_en[r] && (r < rspt_pkg::REEL_COUNT))
                delta = rspt_pkg::UNI_TAB[row][nib[r]];
            else
                delta = rspt_pkg::Z0;
            new_pos = rspt_pkg::wrap_pos(cur.motor_pos[r], delta);
            nxt.motor_pos[r] = new_pos;
            if (new_pos != cur.motor_pos[r])
            begin
                moved[r] = 1'b1;
                nxt.shown_pos[r] = (new_pos == 7'd0) ? 7'd0
                                 : rspt_pkg::STEPS_PER_TURN - new_pos;
            end
            if (bi_en && (r < 4))
                nxt.sensor[r] = (new_pos < 7'd2) || (new_pos > 7'd92);
            // unipolar reels 0..3 report on bits 6 down to 3
            if (uni_en[r] && cfg.uni_opto && (r < 4) && (r < rspt_pkg::REEL_COUNT))
                nxt.sensor[6-r] = window_hit(cfg.window[2*(r & 3) +: 2], new_pos);
        end
        for (int r = 0; r < rspt_pkg::PHASE_REELS; r++)
        begin
            if (lp_en[r] && (r < rspt_pkg::REEL_COUNT))
                nxt.last_phase[r] = nib[r];
        end
    end

endmodule

`default_nettype wire

@@ rtl/reel_stepper_position_tracker.sv @@
`default_nettype none

// Reel stepper position tracker: each accepted beat is one drive port write
// (opcode plus data byte) and yields exactly one result beat holding the
// sensor byte, the mask of reels that moved, and every reel's displayed
// position. A beat is taken every cycle unless the result stalls; the write
// lands in an input register, the phase tables and wrap logic compute the
// next reel state from it, and the state and the result are registered
// together when the input register advances. A stalled result holds
// the next write in the input register, and the input stalls behind it
// until the result is taken.
// Configuration writes take effect at once and are meant for an idle block.

module reel_stepper_position_tracker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [3:0]                         opcode,
    input  wire logic [7:0]                         data_byte,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [7:0]                              sensor_bits,
    output logic [6:0]                              moved_mask,
    output logic [6:0]                              shown_pos_0,
    output logic [6:0]                              shown_pos_1,
    output logic [6:0]                              shown_pos_2,
    output logic [6:0]                              shown_pos_3,
    output logic [6:0]                              shown_pos_4,
    output logic [6:0]                              shown_pos_5,
    output logic [6:0]                              shown_pos_6,
    input  wire logic                               cfg_we,
    input  wire logic [rspt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rspt_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                                   in_valid_reg;
    logic [3:0]                             op_reg;
    logic [7:0]                             data_reg;
    logic                                   out_valid_reg;
    logic [7:0]                             sensor_reg;
    logic [rspt_pkg::NUM_REELS-1:0]         moved_reg;
    logic [rspt_pkg::NUM_REELS-1:0][6:0]    shown_reg;
    rspt_pkg::reel_state_t                  state_reg;
    rspt_pkg::reel_state_t                  state_next;
    rspt_pkg::cfg_t                         cfg_reg;
    logic [rspt_pkg::NUM_REELS-1:0]         moved_next;
    logic                                   advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    rspt_step u_step (
        .cur   (state_reg),
        .cfg   (cfg_reg),
        .op    (op_reg),
        .data  (data_reg),
        .nxt   (state_next),
        .moved (moved_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.motor_pos  <= {rspt_pkg::NUM_REELS{rspt_pkg::POS_RESET}};
            state_reg.shown_pos  <= '0;
            state_reg.last_phase <= '0;
            state_reg.sensor     <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.uni_opto <= 1'b1;
            cfg_reg.window   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rspt_pkg::CFG_UNI_OPTO: cfg_reg.uni_opto <= cfg_data[0];
                rspt_pkg::CFG_WINDOW:   cfg_reg.window   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg   <= opcode;
            data_reg <= data_byte;
        end
        if (advance)
        begin
            sensor_reg <= state_next.sensor;
            moved_reg  <= moved_next;
            shown_reg  <= state_next.shown_pos;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sensor_bits = sensor_reg;
    assign moved_mask  = moved_reg;
    assign shown_pos_0 = shown_reg[0];
    assign shown_pos_1 = shown_reg[1];
    assign shown_pos_2 = shown_reg[2];
    assign shown_pos_3 = shown_reg[3];
    assign shown_pos_4 = shown_reg[4];
    assign shown_pos_5 = shown_reg[5];
    assign shown_pos_6 = shown_reg[6];

endmodule

`default_nettype wire
